// File: rtl/pgwalk_pkg.sv
package pgwalk_pkg;

    localparam int INDEX_BITS  = 9;
    localparam int PRESENT_BIT = 0;
    localparam int HUGE_BIT    = 7;

    // request types on the slave side
    localparam logic [1:0] REQ_TRANSLATE = 2'd0;
    localparam logic [1:0] REQ_MAP       = 2'd1;
    localparam logic [1:0] REQ_UNMAP     = 2'd2;
    localparam logic [1:0] REQ_DATA      = 2'd3;

    // result kinds on the master side
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // walk status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_HUGE_BLOCK  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [51:0] mem_addr;
        logic [63:0] write_data;
        logic [51:0] phys_result;
        logic [1:0]  walk_status;
        logic        tlb_invalidate;
        logic        last_of_run;
    } result_t;

    // table base is 4 KB aligned and idx*8 stays below 4 KB, so the add is a concat
    function automatic logic [51:0] entry_addr(input logic [51:0] tbl,
                                               input logic [1:0]  lvl,
                                               input logic [47:0] virt);
        logic [INDEX_BITS-1:0] idx;
        case (lvl)
            2'd0:    idx = virt[47:39];
            2'd1:    idx = virt[38:30];
            2'd2:    idx = virt[29:21];
            default: idx = virt[20:12];
        endcase
        return {tbl[51:12], idx, 3'b000};
    endfunction

endpackage

// File: rtl/four_level_page_walker.sv
// Four-level page table walker, 512 entries per table, 8-byte entries.
// A translate, map or unmap request starts a walk from root_table_addr
// (set through cfg_wr_en/cfg_wr_data while idle); each level goes out as a
// memory read request on the master side, and the entry comes back as a
// data-return request (tuser = 3) on the slave side. Translate ends with a
// done result carrying the physical address, stopping early at a 1 GB or
// 2 MB huge entry. Map/unmap end with a leaf write followed by a done with
// tlb_invalidate set; a huge entry on their path ends with status 2. A
// missing entry ends any walk with status 1. New requests during a walk and
// data returns while idle are dropped without a result. Rate: one request
// per cycle on the slave side while the result queue has two free slots. A
// request is held in the input register until the core takes it; the core
// handles it combinationally and pushes its first result into the queue,
// whose head register drives the master side. The leaf-write return yields
// two results and so needs two master-side transfers. A four-deep result queue
// decouples the sides; the core takes a request only when two queue slots
// are free. Walk time is set by the memory round trip, not by this block.
module four_level_page_walker
    import pgwalk_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [51:0]  cfg_wr_data,     // root_table_addr
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [231:0] s_axis_tdata,    // virt_addr[47:0], phys_addr[99:48],
                                          // map_flags[163:100], read_data[227:164]
    input  logic [1:0]   s_axis_tuser,    // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata,    // mem_addr[51:0], write_data[115:52],
                                          // phys_result[167:116], walk_status[169:168],
                                          // tlb_invalidate[170]
    output logic [1:0]   m_axis_tuser,    // out_kind
    output logic         m_axis_tlast     // last_of_run
);

    // input register
    logic         in_vld_reg;
    logic [1:0]   in_user_reg;
    logic [227:0] in_data_reg;

    logic         room2;
    logic         take;
    logic [1:0]   push_cnt;
    result_t      res0, res1, head;

    assign take          = in_vld_reg && room2;
    assign s_axis_tready = !in_vld_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_user_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[227:0];
        end
    end

    pgwalk_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (take),
        .in_req      (in_user_reg),
        .in_virt     (in_data_reg[47:0]),
        .in_phys     (in_data_reg[99:48]),
        .in_flags    (in_data_reg[163:100]),
        .in_rdata    (in_data_reg[227:164]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push_cnt    (push_cnt),
        .res0        (res0),
        .res1        (res1)
    );

    // result queue; the master side reads its head register directly
    pgwalk_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tdata = {5'b0, head.tlb_invalidate, head.walk_status, head.phys_result,
                           head.write_data, head.mem_addr};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_run;

endmodule

// File: rtl/pgwalk_core.sv
module pgwalk_core
    import pgwalk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [1:0]  in_req,
    input  logic [47:0] in_virt,
    input  logic [51:0] in_phys,
    input  logic [63:0] in_flags,
    input  logic [63:0] in_rdata,
    input  logic        cfg_wr_en,
    input  logic [51:0] cfg_wr_data,
    output logic [1:0]  push_cnt,
    output result_t     res0,
    output result_t     res1
);

    typedef enum logic {
        PH_IDLE,
        PH_WALK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [47:0] virt_reg, virt_next;
    logic [51:0] frame_reg, frame_next;
    logic [63:0] flags_reg, flags_next;
    logic [1:0]  level_reg, level_next;
    logic [51:0] root_reg;

    logic        translate;
    logic [63:0] map_entry;

    assign translate = (kind_reg == REQ_TRANSLATE);
    assign map_entry = {12'b0, frame_reg[51:12], 12'b0} | flags_reg
                     | (64'd1 << PRESENT_BIT);

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        virt_next  = virt_reg;
        frame_next = frame_reg;
        flags_next = flags_reg;
        level_next = level_reg;
        push_cnt   = 2'd0;
        res0       = '0;
        res1       = '0;
        if (in_valid) begin
            if (phase_reg == PH_IDLE) begin
                if (in_req != REQ_DATA) begin
                    kind_next        = in_req;
                    virt_next        = in_virt;
                    frame_next       = in_phys;
                    flags_next       = in_flags;
                    level_next       = 2'd0;
                    phase_next       = PH_WALK;
                    push_cnt         = 2'd1;
                    res0.kind        = KIND_READ;
                    res0.mem_addr    = entry_addr(root_reg, 2'd0, in_virt);
                    res0.last_of_run = 1'b1;
                end
            end else if (in_req == REQ_DATA) begin
                push_cnt         = 2'd1;
                res0.last_of_run = 1'b1;
                if (!in_rdata[PRESENT_BIT]) begin
                    phase_next       = PH_IDLE;
                    res0.kind        = KIND_DONE;
                    res0.walk_status = ST_NOT_PRESENT;
                end else if ((level_reg == 2'd1 || level_reg == 2'd2)
                             && in_rdata[HUGE_BIT]) begin
                    phase_next = PH_IDLE;
                    res0.kind  = KIND_DONE;
                    if (!translate) begin
                        res0.walk_status = ST_HUGE_BLOCK;
                    end else if (level_reg == 2'd1) begin
                        res0.phys_result = {in_rdata[51:30], virt_reg[29:0]};
                    end else begin
                        res0.phys_result = {in_rdata[51:21], virt_reg[20:0]};
                    end
                end else if (level_reg == 2'd3) begin
                    phase_next       = PH_IDLE;
                    res0.kind        = KIND_DONE;
                    res0.phys_result = {in_rdata[51:12], virt_reg[11:0]};
                end else if (level_reg == 2'd2 && !translate) begin
                    // leaf write then done, both from this one return
                    phase_next          = PH_IDLE;
                    push_cnt            = 2'd2;
                    res0.kind           = KIND_WRITE;
                    res0.mem_addr       = entry_addr(in_rdata[51:0], 2'd3, virt_reg);
                    res0.write_data     = (kind_reg == REQ_MAP) ? map_entry : 64'd0;
                    res0.last_of_run    = 1'b0;
                    res1.kind           = KIND_DONE;
                    res1.tlb_invalidate = 1'b1;
                    res1.last_of_run    = 1'b1;
                end else begin
                    level_next    = level_reg + 2'd1;
                    res0.kind     = KIND_READ;
                    res0.mem_addr = entry_addr(in_rdata[51:0], level_reg + 2'd1, virt_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            kind_reg  <= REQ_TRANSLATE;
            virt_reg  <= '0;
            frame_reg <= '0;
            flags_reg <= '0;
            level_reg <= 2'd0;
            root_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            virt_reg  <= virt_next;
            frame_reg <= frame_next;
            flags_reg <= flags_next;
            level_reg <= level_next;
            if (cfg_wr_en) begin
                root_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// File: rtl/pgwalk_fifo.sv
module pgwalk_fifo
    import pgwalk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room2,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    localparam int DEPTH = 4;

    result_t     mem [DEPTH];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign room2     = (count_reg <= 3'(DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= push1;
        end
    end

endmodule

// File: rtl/pgwalk_chk.sv
module pgwalk_chk
    import pgwalk_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [175:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // queue empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // leaf write is always followed by its done in the same run
    a_write_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_WRITE |-> !m_axis_tlast)
        else $error("write request marked last");

    // entry addresses are 8-byte aligned
    a_addr_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == KIND_READ || m_axis_tuser == KIND_WRITE)
        |-> m_axis_tdata[2:0] == 3'b000)
        else $error("misaligned entry address");

    a_tlb_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[170]
        |-> m_axis_tuser == KIND_DONE && m_axis_tdata[169:168] == ST_OK)
        else $error("tlb invalidate on wrong result");

endmodule

bind four_level_page_walker pgwalk_chk u_chk (.*);

// File: test/walk_checker.sv
module walk_checker
    import pgwalk_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [51:0]  cfg_wr_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [231:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [175:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           outstanding,
    output int           mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {WALK_IDLE, WALK_BUSY} walk_state_t;

    // shadow of the walker
    logic [51:0] root_base = '0;
    walk_state_t walk_state = WALK_IDLE;
    logic [1:0]  walk_op = REQ_TRANSLATE;
    logic [47:0] walk_va = '0;
    logic [51:0] walk_frame = '0;
    logic [63:0] walk_flags = '0;
    logic [1:0]  walk_lvl = '0;

    result_t pending_results[$];
    result_t want;
    int      errs = 0;

    function automatic logic [51:0] slot_addr(input logic [51:0] tbl, input logic [1:0] level);
        int         sh;
        logic [8:0] idx;
        sh  = 12 + INDEX_BITS * (3 - int'(level));
        idx = 9'((walk_va >> sh) & 48'h1FF);
        return {tbl[51:12], 12'h000} + {40'h0, idx, 3'b000};
    endfunction

    function automatic result_t pack_result(input logic [1:0] kind, input logic [51:0] addr,
                                            input logic [63:0] wdata, input logic [51:0] phys,
                                            input logic [1:0] status, input logic tlb,
                                            input logic last);
        return '{kind: kind, mem_addr: addr, write_data: wdata, phys_result: phys,
                 walk_status: status, tlb_invalidate: tlb, last_of_run: last};
    endfunction

    function automatic void predict_walk(input logic [1:0] req, input logic [231:0] data);
        logic [63:0] e;
        logic [63:0] ofs_mask;
        logic [63:0] wd;
        logic        trans;
        e = data[227:164];
        if (walk_state == WALK_IDLE) begin
            if (req == REQ_DATA) return;   // stray return, dropped
            walk_op    = req;
            walk_va    = data[47:0];
            walk_frame = data[99:48];
            walk_flags = data[163:100];
            walk_lvl   = 2'd0;
            walk_state = WALK_BUSY;
            pending_results.push_back(pack_result(KIND_READ, slot_addr(root_base, 2'd0),
                                                  '0, '0, ST_OK, 1'b0, 1'b1));
            return;
        end
        if (req != REQ_DATA) return;       // new request mid-walk, dropped
        trans = (walk_op == REQ_TRANSLATE);
        if (!e[PRESENT_BIT]) begin
            walk_state = WALK_IDLE;
            pending_results.push_back(pack_result(KIND_DONE, '0, '0, '0, ST_NOT_PRESENT,
                                                  1'b0, 1'b1));
        end else if ((walk_lvl == 2'd1 || walk_lvl == 2'd2) && e[HUGE_BIT]) begin
            walk_state = WALK_IDLE;
            ofs_mask = (64'd1 << (12 + INDEX_BITS * (3 - int'(walk_lvl)))) - 64'd1;
            if (trans)
                pending_results.push_back(pack_result(KIND_DONE, '0, '0,
                    52'((e & ~ofs_mask) | ({16'h0, walk_va} & ofs_mask)), ST_OK, 1'b0, 1'b1));
            else
                pending_results.push_back(pack_result(KIND_DONE, '0, '0, '0, ST_HUGE_BLOCK,
                                                      1'b0, 1'b1));
        end else if (walk_lvl == 2'd3) begin
            walk_state = WALK_IDLE;
            pending_results.push_back(pack_result(KIND_DONE, '0, '0, {e[51:12], walk_va[11:0]},
                                                  ST_OK, 1'b0, 1'b1));
        end else if (walk_lvl == 2'd2 && !trans) begin
            // leaf write, no level 3 read for map/unmap
            wd = '0;
            if (walk_op == REQ_MAP)
                wd = {12'h0, walk_frame[51:12], 12'h000} | walk_flags | (64'd1 << PRESENT_BIT);
            walk_state = WALK_IDLE;
            pending_results.push_back(pack_result(KIND_WRITE, slot_addr(e[51:0], 2'd3), wd,
                                                  '0, ST_OK, 1'b0, 1'b0));
            pending_results.push_back(pack_result(KIND_DONE, '0, '0, '0, ST_OK, 1'b1, 1'b1));
        end else begin
            walk_lvl = walk_lvl + 2'd1;
            pending_results.push_back(pack_result(KIND_READ, slot_addr(e[51:0], walk_lvl),
                                                  '0, '0, ST_OK, 1'b0, 1'b1));
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_val,
                                        input logic [63:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                root_base = cfg_wr_data;
            // outputs at this edge come from earlier requests, so pop before predicting
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d", m_axis_tuser);
                    errs++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_kind", want.kind, m_axis_tuser);
                    check_field("mem_addr", want.mem_addr, m_axis_tdata[51:0]);
                    check_field("write_data", want.write_data, m_axis_tdata[115:52]);
                    check_field("phys_result", want.phys_result, m_axis_tdata[167:116]);
                    check_field("walk_status", want.walk_status, m_axis_tdata[169:168]);
                    check_field("tlb_invalidate", want.tlb_invalidate, m_axis_tdata[170]);
                    check_field("last_of_run", want.last_of_run, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_walk(s_axis_tuser, s_axis_tdata);
        end
        outstanding <= pending_results.size();
        mismatches  <= errs;
    end

endmodule

// File: test/four_level_page_walker_test.sv
module four_level_page_walker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pgwalk_pkg::*;

    localparam int          ITEM_GOAL   = 1700;
    localparam int          CHUNK_ITEMS = 250;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [51:0] ROOT_MAX    = 52'hF_FFFF_FFFF_FFFF;

    // how a walk's final entry is built
    localparam int ENT_NEXT   = 0;   // present pointer (leaf at the last level)
    localparam int ENT_ABSENT = 1;   // present bit clear
    localparam int ENT_HUGE   = 2;   // present with huge bit set

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [51:0]  cfg_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [231:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = REQ_TRANSLATE;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    int outstanding;
    int mismatches;
    int cycles = 0;
    int counted = 0;      // requests that do work, stray ones excluded
    bit no_gaps = 1'b0;   // run both sides flat out
    bit hold_go = 1'b0;   // kick off the long receiver stall

    // receiver state
    int stall_left = 0;
    int gap_left = 0;
    bit hold_used = 1'b0;

    always #1 aclk = ~aclk;

    four_level_page_walker u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    walk_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used  = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!no_gaps && $urandom_range(0, 3) == 0)
                gap_left = gap_len();
        end
    end

    // table entry; upper bits random (or all ones) to catch leaks past bit 51
    function automatic logic [63:0] make_entry(input int level, input int how, input bit ones);
        logic [63:0] e;
        e = ones ? '1 : rand64();
        case (how)
            ENT_ABSENT: e[PRESENT_BIT] = 1'b0;
            ENT_HUGE: begin
                e[PRESENT_BIT] = 1'b1;
                e[HUGE_BIT]    = 1'b1;
            end
            default: begin
                e[PRESENT_BIT] = 1'b1;
                // huge bit only matters at levels 1 and 2; left as is elsewhere
                if (level == 1 || level == 2) e[HUGE_BIT] = 1'b0;
            end
        endcase
        return e;
    endfunction

    // one request on the slave side, held until taken
    task automatic offer(input logic [1:0] req, input logic [47:0] va, input logic [51:0] pa,
                         input logic [63:0] flg, input logic [63:0] entry);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {4'h0, entry, flg, pa, va};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // A full walk: the request, then one entry return per level up to stop_lvl,
    // where the walk ends with the entry kind stop_how. Stray requests (data while
    // idle, new request mid-walk) are mixed in at noise_pct percent.
    task automatic walk(input logic [1:0] req, input logic [47:0] va, input logic [51:0] pa,
                        input logic [63:0] flg, input int stop_lvl, input int stop_how,
                        input bit ones, input int noise_pct);
        int last_lvl;
        int how;
        last_lvl = (req == REQ_TRANSLATE) ? 3 : 2;
        if (stop_lvl > last_lvl) stop_lvl = last_lvl;
        // a pointer before the last level, or huge at level 0, would not end the walk
        if (stop_lvl < last_lvl && stop_how == ENT_NEXT) stop_how = ENT_ABSENT;
        if (stop_lvl == 0 && stop_how == ENT_HUGE) stop_how = ENT_ABSENT;
        if ($urandom_range(0, 99) < noise_pct)
            offer(REQ_DATA, 48'(rand64()), 52'(rand64()), rand64(), rand64());
        offer(req, va, pa, flg, ones ? '1 : rand64());
        for (int l = 0; l <= stop_lvl; l++) begin
            if ($urandom_range(0, 99) < noise_pct)
                offer(2'($urandom_range(0, 2)), 48'(rand64()), 52'(rand64()), rand64(),
                      rand64());
            how = (l < stop_lvl) ? ENT_NEXT : stop_how;
            offer(REQ_DATA, 48'(rand64()), 52'(rand64()), rand64(), make_entry(l, how, ones));
        end
        counted += stop_lvl + 2;
    endtask

    // register write once everything has drained and the pipe is quiet
    task automatic set_root(input logic [51:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int          chunk;
        int          next_cfg;
        int          r;
        int          last_lvl;
        int          stop;
        logic [1:0]  req;
        logic [47:0] va;
        logic [63:0] flg;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: root at zero, everything else all ones (huge bit at level 0 ignored)
        set_root('0);
        walk(REQ_TRANSLATE, '1, '1, '1, 3, ENT_NEXT, 1'b1, 0);

        // root at max, low bits set and ignored
        set_root(ROOT_MAX);
        walk(REQ_TRANSLATE, '0, '0, '0, 3, ENT_HUGE, 1'b0, 0);       // huge at level 3 ignored
        walk(REQ_TRANSLATE, 48'(rand64()), '0, '0, 1, ENT_HUGE, 1'b0, 0);  // 1 GB page
        walk(REQ_TRANSLATE, 48'(rand64()), '0, '0, 2, ENT_HUGE, 1'b0, 0);  // 2 MB page
        walk(REQ_TRANSLATE, 48'(rand64()), '0, '0, 0, ENT_ABSENT, 1'b0, 100); // strays + fault
        walk(REQ_MAP, '1, '1, '1, 2, ENT_NEXT, 1'b1, 0);
        walk(REQ_UNMAP, '0, 52'(rand64()), rand64(), 2, ENT_NEXT, 1'b0, 0);
        walk(REQ_MAP, 48'(rand64()), '0, '0, 1, ENT_HUGE, 1'b0, 0);    // huge blocks map
        walk(REQ_UNMAP, 48'(rand64()), '0, '0, 2, ENT_HUGE, 1'b0, 0);  // huge blocks unmap

        // random walks, root and pacing changed every chunk
        chunk    = 0;
        next_cfg = counted;
        while (counted < ITEM_GOAL) begin
            if (counted >= next_cfg) begin
                case (chunk % 4)
                    0:       set_root('0);
                    1:       set_root(ROOT_MAX);
                    default: set_root(52'(rand64()));
                endcase
                no_gaps <= (chunk % 3 == 2);
                if (chunk == 1) hold_go <= 1'b1;   // long stall while requests keep coming
                chunk++;
                next_cfg = counted + CHUNK_ITEMS;
            end
            r   = $urandom_range(0, 9);
            req = (r < 5) ? REQ_TRANSLATE : (r < 8) ? REQ_MAP : REQ_UNMAP;
            last_lvl = (req == REQ_TRANSLATE) ? 3 : 2;
            stop = ($urandom_range(0, 9) < 6) ? last_lvl : $urandom_range(0, last_lvl);
            va = 48'(rand64());
            r  = $urandom_range(0, 19);
            if (r == 0) va = '0;
            else if (r == 1) va = '1;
            r = $urandom_range(0, 9);
            flg = (r == 0) ? '0 : (r == 1) ? '1 : (r < 5) ? 64'($urandom_range(0, 255)) : rand64();
            walk(req, va, 52'(rand64()), flg, stop, $urandom_range(0, 2),
                 $urandom_range(0, 19) == 0, 6);
        end

        // drain, then a few quiet cycles to catch extra results
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: four_level_page_walker.f
rtl/pgwalk_pkg.sv
rtl/pgwalk_core.sv
rtl/pgwalk_fifo.sv
rtl/four_level_page_walker.sv
rtl/pgwalk_chk.sv
test/walk_checker.sv
test/four_level_page_walker_test.sv
